[sv/assert_macros.svh]
// assertion helpers used by the checker file trk_check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle during reset
`define ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication, idle during reset
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

// next-cycle implication that also watches reset itself
`define ASSERT_NEXT_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

[sv/trk_pkg.sv]
// ----------------------------------------------------------------------------
// trk_pkg
// Types, constants and helpers for the transverse rf kick step pipeline.
// ----------------------------------------------------------------------------
package trk_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] slope_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] slope_y;
    logic signed [31:0] path_ct;
    logic signed [31:0] mom_dev;
  } coord_t;

  typedef enum logic [2:0] {
    CFG_KICK_SCALE   = 3'd0,
    CFG_STEP_LENGTH  = 3'd1,
    CFG_WAVE_NUMBER  = 3'd2,
    CFG_PHASE_OFFSET = 3'd3,
    CFG_COS_ORIENT   = 3'd4,
    CFG_SIN_ORIENT   = 3'd5
  } cfg_idx_t;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam int          CW           = 34;  // cordic datapath width
  localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [32:0] ONE_Q28  = 33'sd268435456;
  localparam logic signed [32:0] HALF_Q28 = 33'sd134217728;
  localparam int QW = 34;  // quotient bits
  localparam int DW = 34;  // divisor bits

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[sv/transverse_rf_kick_step_top.sv]
// ----------------------------------------------------------------------------
// transverse_rf_kick_step_top
// One rf deflector kick step per particle: phase, cordic cosine, kick
// division, orientation split and slope/position update, fully pipelined.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       sink       in_valid / in_stall       pos_x .. mom_dev
// out      source     out_valid / out_stall     new_pos_x .. pass_dp
// cfg      sink       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one beat enters per cycle while the pipe is not stalled; it holds the
// cordic rotation stages plus one restoring division stage per quotient
// bit (34). rst is synchronous, clears the valid bits and zeroes the
// configuration registers but cos_orient (32'h4000_0000). out_stall
// freezes the whole pipe while a result beat waits; in_stall follows it.
module transverse_rf_kick_step_top
  import trk_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] slope_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] slope_y,
  input  logic signed [31:0] path_ct,
  input  logic signed [31:0] mom_dev,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] new_pos_x,
  output logic signed [31:0] new_slope_x,
  output logic signed [31:0] new_pos_y,
  output logic signed [31:0] new_slope_y,
  output logic signed [31:0] pass_ct,
  output logic signed [31:0] pass_dp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int CS       = CORDIC_STAGES;
  localparam int ST_COS   = 3 + CS;
  localparam int ST_CXY   = 8 + CS + QW;
  localparam int ST_PR    = 10 + CS + QW;
  localparam int DEPTH    = 11 + CS + QW;

  // configuration registers
  logic signed [31:0] kick_scale;
  logic [30:0]        step_length;
  logic signed [31:0] wave_number;
  logic [31:0]        phase_offset;
  logic signed [31:0] cos_orient;
  logic signed [31:0] sin_orient;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kick_scale   <= '0;
      step_length  <= '0;
      wave_number  <= '0;
      phase_offset <= '0;
      cos_orient   <= 32'sh4000_0000;
      sin_orient   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KICK_SCALE:   kick_scale   <= cfg_data;
        CFG_STEP_LENGTH:  step_length  <= cfg_data[30:0];
        CFG_WAVE_NUMBER:  wave_number  <= cfg_data;
        CFG_PHASE_OFFSET: phase_offset <= cfg_data;
        CFG_COS_ORIENT:   cos_orient   <= cfg_data;
        CFG_SIN_ORIENT:   sin_orient   <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: the whole pipe holds while the output beat waits
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // valid bits and the coordinates travel together down the pipe
  logic   vld [1:DEPTH];
  coord_t crd [1:DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= DEPTH; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[1] <= in_valid;
      for (int k = 2; k <= DEPTH; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crd[1] <= '{pos_x, slope_x, pos_y, slope_y, path_ct, mom_dev};
      for (int k = 2; k <= DEPTH; k++) crd[k] <= crd[k-1];
    end
  end

  // phase product, Q20.44
  logic signed [63:0] ph_prod;
  always_ff @(posedge clk) begin
    if (en) ph_prod <= wave_number * path_ct;
  end

  // fold into [-1/4, 1/4) turn and seed the cordic
  logic signed [CW-1:0] cx [0:CS];
  logic signed [CW-1:0] cy [0:CS];
  logic signed [CW-1:0] cz [0:CS];
  logic                 cneg [0:CS];
  logic [31:0]          ang;
  logic                 fold;

  always_comb begin
    ang  = phase_offset - ph_prod[43:12];
    fold = (ang + QUARTER_TURN) >= HALF_TURN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]   <= CORDIC_START;
      cy[0]   <= '0;
      cz[0]   <= CW'($signed(fold ? ang - HALF_TURN : ang));
      cneg[0] <= fold;
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        cneg[i+1] <= cneg[i];
        if (!cz[i][CW-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - CW'(ATAN_TURNS[i]);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + CW'(ATAN_TURNS[i]);
        end
      end
    end
  end

  // cosine, Q4.30
  logic signed [CW-1:0] cosv;
  always_ff @(posedge clk) begin
    if (en) cosv <= cneg[CS] ? -cx[CS] : cx[CS];
  end

  // kick numerator and divisor 4*(1+dp), clamped at one half
  logic signed [65:0] knum;
  logic [DW-1:0]      kden;
  logic signed [32:0] den_w;

  always_comb begin
    den_w = 33'(crd[ST_COS].mom_dev) + ONE_Q28;
    if (den_w < HALF_Q28) den_w = HALF_Q28;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      knum <= kick_scale * cosv;
      kden <= {den_w[31:0], 2'b00};
    end
  end

  // restoring divider on magnitudes, one quotient bit per stage
  logic [DW-1:0] rem [0:QW];
  logic [QW-1:0] nlo [0:QW];
  logic [QW-1:0] quo [0:QW];
  logic [DW-1:0] dvs [0:QW];
  logic          dsg [0:QW];
  logic [65:0]   kmag;

  assign kmag = knum[65] ? 66'(-knum) : 66'(knum);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DW'(kmag[63:QW]);  // top part is known below the divisor
      nlo[0] <= kmag[QW-1:0];
      quo[0] <= '0;
      dvs[0] <= kden;
      dsg[0] <= knum[65];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW:0] trial;
    assign trial = {rem[k], nlo[k][QW-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        nlo[k+1] <= {nlo[k][QW-2:0], 1'b0};
        dvs[k+1] <= dvs[k];
        dsg[k+1] <= dsg[k];
        if (trial >= {1'b0, dvs[k]}) begin
          rem[k+1] <= DW'(trial - {1'b0, dvs[k]});
          quo[k+1] <= {quo[k][QW-2:0], 1'b1};
        end else begin
          rem[k+1] <= trial[DW-1:0];
          quo[k+1] <= {quo[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  // signed, saturated kick
  logic signed [31:0] da;
  logic [QW-1:0]      qf;
  assign qf = quo[QW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (!dsg[QW]) begin
        da <= (qf > QW'(32'h7fff_ffff)) ? 32'sh7fff_ffff : qf[31:0];
      end else begin
        da <= (qf > QW'(32'h8000_0000)) ? 32'sh8000_0000 : -qf[31:0];
      end
    end
  end

  // orientation split
  logic signed [63:0] ox_prod, oy_prod;
  always_ff @(posedge clk) begin
    if (en) begin
      ox_prod <= cos_orient * da;
      oy_prod <= sin_orient * da;
    end
  end

  logic signed [31:0] kx, ky;
  always_ff @(posedge clk) begin
    if (en) begin
      kx <= sat32(66'(ox_prod >>> 30));
      ky <= sat32(66'(oy_prod >>> 30));
    end
  end

  // new slopes
  logic signed [31:0] sx_new, sy_new, kx_d, ky_d;
  always_ff @(posedge clk) begin
    if (en) begin
      sx_new <= sat32(66'(crd[ST_CXY].slope_x) + 66'(kx));
      sy_new <= sat32(66'(crd[ST_CXY].slope_y) + 66'(ky));
      kx_d   <= kx;
      ky_d   <= ky;
    end
  end

  // drift products against the step length
  logic signed [31:0] len_s;
  logic signed [63:0] kxl, kyl, sxl, syl;
  logic signed [31:0] sx_d, sy_d;
  assign len_s = $signed({1'b0, step_length});

  always_ff @(posedge clk) begin
    if (en) begin
      kxl  <= kx_d * len_s;
      kyl  <= ky_d * len_s;
      sxl  <= sx_new * len_s;
      syl  <= sy_new * len_s;
      sx_d <= sx_new;
      sy_d <= sy_new;
    end
  end

  // position update and output register
  logic signed [65:0] dx, dy;
  logic signed [31:0] px_w, py_w;
  coord_t             cpr;

  always_comb begin
    cpr  = crd[ST_PR];
    dx   = (66'(kxl) >>> 1) + 66'(sxl);
    dy   = (66'(kyl) >>> 1) + 66'(syl);
    px_w = sat32(66'(cpr.pos_x) + (dx >>> 24));
    py_w = sat32(66'(cpr.pos_y) + (dy >>> 24));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (step_length == '0) begin
        new_pos_x   <= cpr.pos_x;
        new_slope_x <= cpr.slope_x;
        new_pos_y   <= cpr.pos_y;
        new_slope_y <= cpr.slope_y;
      end else begin
        new_pos_x   <= px_w;
        new_slope_x <= sx_d;
        new_pos_y   <= py_w;
        new_slope_y <= sy_d;
      end
      pass_ct <= cpr.path_ct;
      pass_dp <= cpr.mom_dev;
    end
  end

  assign out_valid = vld[DEPTH];

endmodule

[sv/trk_check.sv]
// ----------------------------------------------------------------------------
// trk_check
// Port-level checks for the transverse rf kick step pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trk_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic signed [31:0] pos_x,
  input logic signed [31:0] slope_x,
  input logic signed [31:0] pos_y,
  input logic signed [31:0] slope_y,
  input logic signed [31:0] path_ct,
  input logic signed [31:0] mom_dev,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] new_pos_x,
  input logic signed [31:0] new_slope_x,
  input logic signed [31:0] new_pos_y,
  input logic signed [31:0] new_slope_y,
  input logic signed [31:0] pass_ct,
  input logic signed [31:0] pass_dp,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [31:0]        cfg_data
);

  // input backs up exactly when a finished beat is held at the output
  `ASSERT_NOW(a_stall_follows_out, clk, rst, 1'b1, in_stall == (out_valid && out_stall))

  // the pipe is empty after reset
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall,
               $stable(new_pos_x) && $stable(new_slope_y) && $stable(pass_ct))

endmodule

bind transverse_rf_kick_step_top trk_check u_trk_check (.*);
